>>> hdl/sti_pkg.sv
`default_nettype none
package sti_pkg;
    localparam int CordicSteps = 16;
    localparam int AtanEntries = 24;
    localparam int XW = 50;

    typedef enum logic [2:0] {
        REG_RADIUS = 3'd0,
        REG_WIDTH  = 3'd1,
        REG_START  = 3'd2,
        REG_POWER  = 3'd3,
        REG_JAM    = 3'd4,
        REG_AUTO   = 3'd5,
        REG_RATE   = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_CORDIC,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic               mode;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic        [9:0]  ms;
    } t_item;

    typedef struct packed {
        logic        in_sector;
        logic [22:0] jam_power;
        logic [15:0] heading;
    } t_result;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

>>> hdl/sti_if.sv
`default_nettype none
interface sti_in_if;
    logic          valid;
    logic          ready;
    sti_pkg::t_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sti_out_if;
    logic            valid;
    logic            ready;
    sti_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/sector_test_inverse_square_top.sv
`default_nettype none
// a query for a hit with power on goes from input transfer to result valid through:
//   take, square, cordic, divide, output
// in reach without power, out of reach and tick queries take fewer steps, plus output stalls
// one item in the engine at a time; two-entry input queue
// reset (synchronous, active low) loads register defaults and heading zero
module sector_test_inverse_square_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [22:0] i_cfg_data,
    sti_in_if.sink           in_ch,
    sti_out_if.source        out_ch
);
    sti_pkg::t_item w_item;
    logic           w_valid, w_take;

    // front queue takes transfers independent of engine
    sti_front u_front (
        .i_clk, .i_rst_n, .in_ch,
        .o_item(w_item), .o_valid(w_valid), .i_take(w_take)
    );

    sti_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_item(w_item), .i_valid(w_valid), .o_take(w_take), .out_ch
    );
endmodule
`default_nettype wire

>>> hdl/sti_front.sv
`default_nettype none
// two-entry queue between the input channel and the engine
module sti_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    sti_in_if.sink             in_ch,
    output sti_pkg::t_item     o_item,
    output logic               o_valid,
    input  wire logic          i_take
);
    sti_pkg::t_item r_q [2];
    logic           r_rd, r_wr;
    logic [1:0]     r_cnt;
    logic           w_push, w_pop;

    assign in_ch.ready = (r_cnt != 2'd2);
    assign w_push = in_ch.valid && in_ch.ready;
    assign w_pop  = i_take && o_valid;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 1'b0;
            r_wr <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= in_ch.data;
    end
endmodule
`default_nettype wire

>>> hdl/sti_back.sv
`default_nettype none
// sequencer: squares, cordic, restoring divide, output register
module sti_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [22:0]   i_cfg_data,
    input  wire sti_pkg::t_item i_item,
    input  wire logic          i_valid,
    output logic               o_take,
    sti_out_if.source          out_ch
);
    localparam int XW = sti_pkg::XW;

    logic [22:0] r_radius;
    logic [16:0] r_width;
    logic [15:0] r_power;
    logic        r_jam, r_auto;
    logic signed [20:0] r_rate;
    logic [23:0] r_dir;

    sti_pkg::t_state r_st, n_st;
    sti_pkg::t_item  r_it;
    logic [1:0]  r_sq;
    logic [47:0] r_d2, r_r2;
    logic signed [XW-1:0] r_x, r_y;
    logic [31:0] r_z;
    logic [4:0]  r_i;
    logic        r_inr;
    logic [29:0] r_quo;
    logic [48:0] r_rem;
    logic [47:0] r_den;
    logic [5:0]  r_k;
    logic        r_hit;
    logic        r_ov;
    sti_pkg::t_result r_res;

    // full-width rotation step, wrapped into the accumulator
    logic signed [31:0] w_delta;
    assign w_delta = r_rate * $signed({1'b0, i_item.ms});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 23'd3000;
            r_width  <= 17'd10923;
            r_power  <= 16'd1000;
            r_jam    <= 1'b0;
            r_auto   <= 1'b0;
            r_rate   <= 21'sd1398;
            r_dir    <= 24'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sti_pkg::REG_RADIUS: r_radius <= i_cfg_data;
                sti_pkg::REG_WIDTH:  r_width  <= i_cfg_data[16:0];
                sti_pkg::REG_START:  r_dir    <= {i_cfg_data[15:0], 8'd0};
                sti_pkg::REG_POWER:  r_power  <= i_cfg_data[15:0];
                sti_pkg::REG_JAM:    r_jam    <= i_cfg_data[0];
                sti_pkg::REG_AUTO:   r_auto   <= i_cfg_data[0];
                sti_pkg::REG_RATE:   r_rate   <= {i_cfg_data[20:0]};
                default: ;
            endcase
        end else if (r_st == sti_pkg::ST_IDLE && i_valid && i_item.mode && r_auto) begin
            r_dir <= r_dir + w_delta[23:0];
        end
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            sti_pkg::ST_IDLE:   if (i_valid && o_take) n_st = i_item.mode ? sti_pkg::ST_OUT
                                                                          : sti_pkg::ST_SQ;
            sti_pkg::ST_SQ:     if (r_sq == 2'd3) n_st = sti_pkg::ST_CORDIC;
            sti_pkg::ST_CORDIC: if (!r_inr || r_i == 5'(sti_pkg::CordicSteps - 1))
                                    n_st = sti_pkg::ST_DIV;
            sti_pkg::ST_DIV:    if (r_k != 6'd31 && (!(r_hit && r_jam) || r_k == 6'd0))
                                    n_st = sti_pkg::ST_OUT;
            sti_pkg::ST_OUT:    if (!r_ov || out_ch.ready) n_st = sti_pkg::ST_IDLE;
            default:            n_st = sti_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_take = (r_st == sti_pkg::ST_IDLE) && !i_cfg_we;
    end

    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_res;

    logic signed [23:0] w_sqop;
    logic signed [XW-1:0] w_xs, w_ys;
    logic [31:0] w_dir, w_half, w_lo, w_hi, w_t;
    logic        w_arc;
    logic [47:0] w_dd;
    logic [48:0] w_trial;

    always_comb begin
        unique case (r_sq)
            2'd0: w_sqop = r_it.x;
            2'd1: w_sqop = r_it.y;
            2'd2: w_sqop = r_it.z;
            default: w_sqop = 24'sd0;
        endcase
        w_xs = r_x >>> r_i;
        w_ys = r_y >>> r_i;
        w_t = (r_it.x == 24'sd0 && r_it.y == 24'sd0) ? 32'd0 : r_z;
        w_dir = {r_dir, 8'd0};
        w_half = {r_width[16:0], 15'd0};
        w_lo = w_dir - w_half;
        w_hi = w_dir + w_half;
        if (r_width[16]) w_arc = 1'b1;
        else if (w_lo > w_hi) w_arc = (w_t >= w_lo) || (w_t <= w_hi);
        else w_arc = (w_t >= w_lo) && (w_t <= w_hi);
        w_dd = (r_d2 < 48'd100) ? 48'd100 : r_d2;
        w_trial = {r_rem[47:0], r_quo[29]} - {1'b0, r_den};
    end

    logic signed [47:0] w_prod;
    assign w_prod = w_sqop * w_sqop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= sti_pkg::ST_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == sti_pkg::ST_OUT && (!r_ov || out_ch.ready)) r_ov <= 1'b1;
            else if (out_ch.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            sti_pkg::ST_IDLE: begin
                r_it <= i_item;
                r_sq <= 2'd0;
                r_d2 <= 48'd0;
                r_hit <= 1'b0;
                r_r2 <= 48'(r_radius) * 48'(r_radius);
            end
            sti_pkg::ST_SQ: begin
                if (r_sq != 2'd3) r_d2 <= r_d2 + 48'(w_prod);
                r_sq <= r_sq + 2'd1;
                r_inr <= (r_d2 <= r_r2);
                r_i <= 5'd0;
                if (r_it.x < 0) begin
                    r_x <= -(XW'(r_it.x) <<< 24);
                    r_y <= -(XW'(r_it.y) <<< 24);
                    r_z <= 32'h80000000;
                end else begin
                    r_x <= XW'(r_it.x) <<< 24;
                    r_y <= XW'(r_it.y) <<< 24;
                    r_z <= 32'd0;
                end
            end
            sti_pkg::ST_CORDIC: begin
                if (r_y >= 0) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + sti_pkg::atan_turn(r_i);
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - sti_pkg::atan_turn(r_i);
                end
                r_i <= r_i + 5'd1;
                if (n_st == sti_pkg::ST_DIV) begin
                    // r_z final only after this update; hit computed next state
                    r_k <= 6'd31;
                end
            end
            sti_pkg::ST_DIV: begin
                if (r_k == 6'd31) begin
                    r_hit <= r_inr && w_arc;
                    r_quo <= 30'(r_power) * 30'd10000;
                    r_rem <= 49'd0;
                    r_den <= w_dd;
                    r_k <= 6'd30;
                end else if (r_k != 6'd0) begin
                    if (!w_trial[48]) r_rem <= w_trial;
                    else r_rem <= {r_rem[47:0], r_quo[29]};
                    r_quo <= {r_quo[28:0], !w_trial[48]};
                    r_k <= r_k - 6'd1;
                end
            end
            sti_pkg::ST_OUT: begin
                if (!r_ov || out_ch.ready) begin
                    r_res.in_sector <= r_it.mode ? 1'b0 : r_hit;
                    r_res.jam_power <= (!r_it.mode && r_hit && r_jam) ? r_quo[22:0] : 23'd0;
                    r_res.heading <= r_dir[23:8];
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> hdl/sti_checker.sv
`default_nettype none
module sti_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_sector,
    input wire logic [22:0] out_power
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_pow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_sector |-> out_power == 23'd0) else $error("power outside");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind sector_test_inverse_square_top sti_checker u_chk (
    .i_clk, .i_rst_n, .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_sector(out_ch.data.in_sector),
    .out_power(out_ch.data.jam_power)
);
`default_nettype wire
